// ----- rtl/rtt_pkg.sv -----
// ----------------------------------------------------------------------------
// rtt_pkg: shared types and constants
// Opcodes, status codes, field widths and the command and response beats
// passed between the front end, the queues and the table engine.
// ----------------------------------------------------------------------------
package rtt_pkg;

    localparam int OP_W    = 2;
    localparam int ID_W    = 32;
    localparam int TMO_W   = 31;
    localparam int NOW_W   = 62;
    localparam int HND_W   = 16;
    localparam int TPS_W   = 30;
    localparam int DL_W    = 63;
    localparam int ST_W    = 2;
    localparam int PROD_W  = TMO_W + TPS_W;
    localparam int REM_W   = 10;

    // divide by 1000 in 16-bit chunks, each chunk by reciprocal multiply
    localparam int DIV_CH    = 16;
    localparam int DIV_W     = 64;
    localparam int DIV_STEPS = DIV_W / DIV_CH;
    localparam int TRIAL_W   = REM_W + DIV_CH;
    localparam int RECIP_W   = 27;
    localparam int RECIP_SH  = 36;

    localparam logic [RECIP_W-1:0] RECIP_M     = 27'd68719477;

    localparam logic [REM_W:0]   MS_PER_SECOND = 11'd1000;
    localparam logic [TPS_W-1:0] TPS_RESET     = 30'd1000000;

    localparam logic [OP_W-1:0] OP_ADD      = 2'd0;
    localparam logic [OP_W-1:0] OP_EXT_ID   = 2'd1;
    localparam logic [OP_W-1:0] OP_EXT_MIN  = 2'd2;
    localparam logic [OP_W-1:0] OP_EXT_EXP  = 2'd3;

    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_NONE = 2'd1;
    localparam logic [ST_W-1:0] ST_DUP  = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [ID_W-1:0]  id;
        logic [NOW_W-1:0] now;
        logic [DL_W-1:0]  dl;
        logic [HND_W-1:0] hnd;
    } t_cmd;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [ID_W-1:0]  id;
        logic [HND_W-1:0] hnd;
    } t_rsp;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [DL_W-1:0]  dl;
        logic [HND_W-1:0] hnd;
    } t_slot;

endpackage

// ----- rtl/rtt_ram.sv -----
// ----------------------------------------------------------------------------
// rtt_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rtt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/rtt_fifo.sv -----
// ----------------------------------------------------------------------------
// rtt_fifo: small register queue
// Holds a few beats between two stages so each side can stall on its own.
// ----------------------------------------------------------------------------
module rtt_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_buf [DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [AW:0]      r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_buf[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_buf[r_wp] <= i_data;
        end
    end
endmodule

// ----- rtl/rtt_front.sv -----
// ----------------------------------------------------------------------------
// rtt_front: request intake and deadline computation
// Accepts one request, converts an add's timeout into ticks with a multiply
// and a chunked reciprocal divide by 1000, and hands a command to the queue.
// ----------------------------------------------------------------------------
module rtt_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    output logic                        o_full,
    input  logic [rtt_pkg::OP_W-1:0]    i_opcode,
    input  logic [rtt_pkg::ID_W-1:0]    i_request_id,
    input  logic [rtt_pkg::TMO_W-1:0]   i_timeout_ms,
    input  logic [rtt_pkg::NOW_W-1:0]   i_now_tick,
    input  logic [rtt_pkg::HND_W-1:0]   i_handle_in,
    input  logic                        i_cfg_we,
    input  logic [rtt_pkg::TPS_W-1:0]   i_cfg_wdata,
    output logic                        o_cmd_push,
    output rtt_pkg::t_cmd               o_cmd,
    input  logic                        i_cmd_full
);
    import rtt_pkg::*;

    typedef enum logic [1:0] {F_IDLE, F_MUL, F_DIV, F_PUSH} t_fstate;

    t_fstate                    r_state;
    logic [TPS_W-1:0]           r_tps;
    logic [OP_W-1:0]            r_op;
    logic [ID_W-1:0]            r_id;
    logic [TMO_W-1:0]           r_tmo;
    logic [NOW_W-1:0]           r_now;
    logic [HND_W-1:0]           r_hnd;
    logic [DIV_W-1:0]           r_div;
    logic [REM_W-1:0]           r_rem;
    logic [5:0]                 r_cnt;
    logic [TRIAL_W-1:0]         trial;
    logic [TRIAL_W+RECIP_W-1:0] recip;
    logic [DIV_CH-1:0]          qdig;
    logic [TRIAL_W-1:0]         qk;
    logic [TRIAL_W-1:0]         n_rem;

    // one chunk: remainder so far joined with the next 16 dividend bits
    assign trial = {r_rem, r_div[DIV_W-1 -: DIV_CH]};
    assign recip = {{RECIP_W{1'b0}}, trial} * {{TRIAL_W{1'b0}}, RECIP_M};
    assign qdig  = recip[RECIP_SH +: DIV_CH];
    // q * 1000 as q * 1024 - q * 16 - q * 8
    assign qk    = {qdig, 10'b0} - {6'b0, qdig, 4'b0} - {7'b0, qdig, 3'b0};
    assign n_rem = trial - qk;

    assign o_full     = (r_state != F_IDLE);
    assign o_cmd_push = (r_state == F_PUSH);

    // Deadline stays below 2^63-1, so the 63-bit sum never wraps.
    always_comb begin
        o_cmd.op  = r_op;
        o_cmd.id  = r_id;
        o_cmd.now = r_now;
        o_cmd.hnd = r_hnd;
        o_cmd.dl  = (r_op == OP_ADD) ? {1'b0, r_now} + {2'b0, r_div[PROD_W-1:0]} : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_tps   <= TPS_RESET;
        end else begin
            if (i_cfg_we) begin
                r_tps <= i_cfg_wdata;
            end
            case (r_state)
                F_IDLE: begin
                    if (i_push) begin
                        r_state <= (i_opcode == OP_ADD) ? F_MUL : F_PUSH;
                    end
                end
                F_MUL:  r_state <= F_DIV;
                F_DIV: begin
                    if (r_cnt == '0) begin
                        r_state <= F_PUSH;
                    end
                end
                F_PUSH: begin
                    if (!i_cmd_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            F_IDLE: begin
                if (i_push) begin
                    r_op  <= i_opcode;
                    r_id  <= i_request_id;
                    r_tmo <= i_timeout_ms;
                    r_now <= i_now_tick;
                    r_hnd <= i_handle_in;
                end
            end
            F_MUL: begin
                r_div <= DIV_W'(PROD_W'(r_tmo) * PROD_W'(r_tps));
                r_rem <= '0;
                r_cnt <= 6'(DIV_STEPS - 1);
            end
            F_DIV: begin
                // shift the quotient chunk in where the dividend chunk shifts out
                r_div <= {r_div[DIV_W-DIV_CH-1:0], qdig};
                r_rem <= n_rem[REM_W-1:0];
                r_cnt <= r_cnt - 1'b1;
            end
            default: ;
        endcase
    end
endmodule

// ----- rtl/rtt_back.sv -----
// ----------------------------------------------------------------------------
// rtt_back: table engine
// Scans the slot table one entry a cycle for id match, first free slot and
// earliest deadline, then updates the table and emits one response.
// ----------------------------------------------------------------------------
module rtt_back #(
    parameter int ENTRIES = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_empty,
    input  rtt_pkg::t_cmd i_cmd,
    output logic          o_cmd_pop,
    output logic          o_rsp_push,
    output rtt_pkg::t_rsp o_rsp,
    input  logic          i_rsp_full
);
    import rtt_pkg::*;

    localparam int AW = $clog2(ENTRIES);

    typedef enum logic [1:0] {B_IDLE, B_SCAN, B_WAIT, B_DONE} t_bstate;

    t_bstate          r_state;
    t_cmd             r_cmd;
    logic [ENTRIES-1:0] r_valid;
    logic [AW-1:0]    r_addr;
    logic             r_rd_act;
    logic [AW-1:0]    r_rd_idx;
    logic             r_rd_val;
    t_slot            rd_slot;

    logic             r_m_f;
    logic [AW-1:0]    r_m_idx;
    logic [ID_W-1:0]  r_m_id;
    logic [HND_W-1:0] r_m_hnd;
    logic             r_fr_f;
    logic [AW-1:0]    r_fr_idx;
    logic             r_b_f;
    logic [AW-1:0]    r_b_idx;
    logic [DL_W-1:0]  r_b_dl;
    logic [ID_W-1:0]  r_b_id;
    logic [HND_W-1:0] r_b_hnd;

    logic             fin;
    logic             take_min;
    logic             wr_en;
    t_slot            wr_slot;

    assign fin       = (r_state == B_DONE) && !i_rsp_full;
    assign o_cmd_pop = (r_state == B_IDLE) && !i_cmd_empty;
    assign o_rsp_push = fin;
    assign take_min  = r_b_f && !(r_cmd.op == OP_EXT_EXP && r_b_dl > {1'b0, r_cmd.now});
    assign wr_en     = fin && r_cmd.op == OP_ADD && !r_m_f && r_fr_f;

    assign wr_slot.id  = r_cmd.id;
    assign wr_slot.dl  = r_cmd.dl;
    assign wr_slot.hnd = r_cmd.hnd;

    rtt_ram #(.WIDTH($bits(t_slot)), .DEPTH(ENTRIES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_fr_idx),
        .i_wdata (wr_slot),
        .i_raddr (r_addr),
        .o_rdata (rd_slot)
    );

    always_comb begin
        o_rsp.status = ST_NONE;
        o_rsp.id     = '0;
        o_rsp.hnd    = '0;
        case (r_cmd.op)
            OP_ADD: begin
                o_rsp.status = r_m_f ? ST_DUP : (r_fr_f ? ST_OK : ST_FULL);
            end
            OP_EXT_ID: begin
                if (r_m_f) begin
                    o_rsp.status = ST_OK;
                    o_rsp.id     = r_m_id;
                    o_rsp.hnd    = r_m_hnd;
                end
            end
            default: begin
                if (take_min) begin
                    o_rsp.status = ST_OK;
                    o_rsp.id     = r_b_id;
                    o_rsp.hnd    = r_b_hnd;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_valid  <= '0;
            r_rd_act <= 1'b0;
        end else begin
            r_rd_act <= (r_state == B_SCAN);
            case (r_state)
                B_IDLE: begin
                    if (!i_cmd_empty) begin
                        r_state <= B_SCAN;
                    end
                end
                B_SCAN: begin
                    if (r_addr == AW'(ENTRIES - 1)) begin
                        r_state <= B_WAIT;
                    end
                end
                B_WAIT: r_state <= B_DONE;
                B_DONE: begin
                    if (!i_rsp_full) begin
                        r_state <= B_IDLE;
                        if (wr_en) begin
                            r_valid[r_fr_idx] <= 1'b1;
                        end else if (r_cmd.op == OP_EXT_ID && r_m_f) begin
                            r_valid[r_m_idx] <= 1'b0;
                        end else if (r_cmd.op != OP_ADD && r_cmd.op != OP_EXT_ID
                                     && take_min) begin
                            r_valid[r_b_idx] <= 1'b0;
                        end
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_addr;
        r_rd_val <= r_valid[r_addr];
        if (r_state == B_IDLE) begin
            r_cmd  <= i_cmd;
            r_addr <= '0;
            r_m_f  <= 1'b0;
            r_fr_f <= 1'b0;
            r_b_f  <= 1'b0;
        end else if (r_state == B_SCAN && r_addr != AW'(ENTRIES - 1)) begin
            r_addr <= r_addr + 1'b1;
        end
        if (r_rd_act) begin
            if (r_rd_val && rd_slot.id == r_cmd.id && !r_m_f) begin
                r_m_f   <= 1'b1;
                r_m_idx <= r_rd_idx;
                r_m_id  <= rd_slot.id;
                r_m_hnd <= rd_slot.hnd;
            end
            if (!r_rd_val && !r_fr_f) begin
                r_fr_f   <= 1'b1;
                r_fr_idx <= r_rd_idx;
            end
            // strict compare keeps the lowest slot on equal deadlines
            if (r_rd_val && (!r_b_f || rd_slot.dl < r_b_dl)) begin
                r_b_f   <= 1'b1;
                r_b_idx <= r_rd_idx;
                r_b_dl  <= rd_slot.dl;
                r_b_id  <= rd_slot.id;
                r_b_hnd <= rd_slot.hnd;
            end
        end
    end
endmodule

// ----- rtl/request_timeout_tracker.sv -----
// ----------------------------------------------------------------------------
// request_timeout_tracker: outstanding request table with deadlines
// Tracks up to ENTRIES requests by id, deadline and handle; supports add,
// extract by id, extract earliest and extract earliest if expired.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue: drive the request fields and push; a beat is taken
//   on an edge with push high and full low. Output side is a queue too: while
//   empty is low the oldest response sits on o_status/o_found_id/o_handle_out;
//   pop it with pop high.
//   The front end takes a request and holds full high while it works: an
//   extract goes straight to the push, while an add first runs a multiply and a
//   four-step reciprocal divide by 1000 of the 61-bit timeout product.
//   A two-beat command queue feeds the table engine, which scans the slot RAM
//   one entry a cycle, so the front end can take a new request while the
//   engine still works on an earlier one; the engine handles one at a time.
//   When the receiver stalls, responses collect in a two-beat output queue,
//   then the engine holds its finished response, then the command queue fills
//   and finally full stays high.
//   Reset clears all valid bits, the queues and sets ticks_per_second to
//   1000000; slot RAM contents are left as they are.
//   Write ticks_per_second through i_cfg_we/i_cfg_wdata only while idle.
// ----------------------------------------------------------------------------
module request_timeout_tracker #(
    parameter int ENTRIES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_opcode,
    input  logic [31:0] i_request_id,
    input  logic [30:0] i_timeout_ms,
    input  logic [61:0] i_now_tick,
    input  logic [15:0] i_handle_in,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_status,
    output logic [31:0] o_found_id,
    output logic [15:0] o_handle_out,
    input  logic        i_cfg_we,
    input  logic [29:0] i_cfg_wdata
);
    import rtt_pkg::*;

    // front end to command queue
    logic  cmd_push, cmd_full, cmd_empty, cmd_pop;
    t_cmd  cmd_in, cmd_out;
    // engine to response queue
    logic  rsp_push, rsp_full;
    t_rsp  rsp_in, rsp_out;

    rtt_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_opcode     (i_opcode),
        .i_request_id (i_request_id),
        .i_timeout_ms (i_timeout_ms),
        .i_now_tick   (i_now_tick),
        .i_handle_in  (i_handle_in),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_cmd_push   (cmd_push),
        .o_cmd        (cmd_in),
        .i_cmd_full   (cmd_full)
    );

    rtt_fifo #(.WIDTH($bits(t_cmd)), .DEPTH(2)) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_out),
        .o_empty (cmd_empty)
    );

    rtt_back #(.ENTRIES(ENTRIES)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (cmd_empty),
        .i_cmd       (cmd_out),
        .o_cmd_pop   (cmd_pop),
        .o_rsp_push  (rsp_push),
        .o_rsp       (rsp_in),
        .i_rsp_full  (rsp_full)
    );

    // hold responses until the receiver pops them
    rtt_fifo #(.WIDTH($bits(t_rsp)), .DEPTH(2)) u_rsp_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rsp_push),
        .i_data  (rsp_in),
        .o_full  (rsp_full),
        .i_pop   (pop),
        .o_data  (rsp_out),
        .o_empty (empty)
    );

    assign o_status     = rsp_out.status;
    assign o_found_id   = rsp_out.id;
    assign o_handle_out = rsp_out.hnd;
endmodule
